// ----- sv/sthr_pkg.sv -----
// ----------------------------------------------------------------------------
// Skinned triangle height raster package
// Shared types, field layouts, codes and fixed-point constants.
// ----------------------------------------------------------------------------
package sthr_pkg;

  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int MAX_VERTICES_DEF  = 1024;
  localparam int MAX_COLUMNS_DEF   = 64;
  localparam int MAX_ROWS_DEF      = 64;

  localparam int GX_W   = 29;
  localparam int BB_W   = 13;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 64;
  localparam int DET_W  = 60;
  localparam int DIV_W  = 59;
  localparam int MA_W   = 34;
  localparam int MB_W   = 30;
  localparam int Q_W    = 17;
  localparam int DIF_W  = 30;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_INFL  = 3'd1;
  localparam logic [2:0] MODE_TRI   = 3'd2;
  localparam logic [2:0] MODE_WRITE = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  localparam logic signed [MA_W-1:0] OFFSET_X    = 34'sd4129;
  localparam logic signed [MA_W-1:0] OFFSET_Z    = 34'sd1704;
  localparam logic signed [35:0]     HEIGHT_BIAS = 36'sd43;
  localparam logic signed [GX_W-1:0] GRID_LIMIT  = 29'sd134217728;
  localparam logic [Q_W-1:0]         WEIGHT_ONE  = 17'd65536;

  typedef enum logic [2:0] {
    CFG_GRID_COLUMNS, CFG_GRID_ROWS, CFG_INV_CELL_X, CFG_INV_CELL_Z,
    CFG_BED_ORIGIN_X, CFG_BED_ORIGIN_Z
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_INFL, OP_TRI, OP_WRH, OP_RDH, OP_NOP
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_INF_MX, ST_INF_MY, ST_INF_MZ, ST_INF_AZ,
    ST_PRJ_X, ST_PRJ_Z, ST_PRJ_W,
    ST_TRI_B, ST_TRI_C, ST_TRI_D, ST_TRI_DIF,
    ST_DET1, ST_DET2, ST_DET3, ST_BOX, ST_BOX_CHK,
    ST_PT_SET, ST_NU1, ST_NU2, ST_NV1, ST_NV2, ST_PT_NV, ST_PT_TST,
    ST_DIV_U, ST_DIV_V, ST_HGT1, ST_HGT2, ST_HGT3, ST_HGT_WR, ST_PT_NEXT,
    ST_RD, ST_RD_W, ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [11:0]        index;
    logic [1:0]         slot;
    logic [9:0]         ref_a;
    logic [9:0]         ref_b;
    logic [9:0]         ref_c;
    logic [16:0]        weight;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    op_t      op;
    in_item_t item;
  } q_item_t;

  typedef struct packed {
    logic [6:0]         grid_columns;
    logic [6:0]         grid_rows;
    logic [23:0]        inv_cell_x;
    logic [23:0]        inv_cell_z;
    logic signed [31:0] bed_origin_x;
    logic signed [31:0] bed_origin_z;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } part_t;

  typedef struct packed {
    logic signed [GX_W-1:0] gx;
    logic signed [31:0]     hy;
    logic signed [GX_W-1:0] gz;
  } vtx_t;

endpackage

// ----- sv/sthr_front.sv -----
// ----------------------------------------------------------------------------
// Front end
// Accepts input items, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sthr_front import sthr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     q_pop
);

  q_item_t    buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  q_item_t    entry;

  function automatic op_t classify(input logic [2:0] mode);
    op_t op;
    case (mode)
      MODE_LOAD:  op = OP_LOAD;
      MODE_INFL:  op = OP_INFL;
      MODE_TRI:   op = OP_TRI;
      MODE_WRITE: op = OP_WRH;
      MODE_READ:  op = OP_RDH;
      default:    op = OP_NOP;
    endcase
    return op;
  endfunction

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rd_ptr_r];

  always_comb begin
    entry.op   = classify(in_item.mode);
    entry.item = in_item;
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = (q_pop && q_valid) ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ----- sv/sthr_div.sv -----
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving floor(n * 2^16 / d) for n <= d, one bit a cycle.
// ----------------------------------------------------------------------------
module sthr_div import sthr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  logic [DIV_W:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             first_r;
  logic             done_r;
  logic [DIV_W:0]   rs;
  logic             ge;

  always_comb begin
    rs      = first_r ? rem_r : {rem_r[DIV_W-1:0], 1'b0};
    ge      = (rs >= {1'b0, den});
    rem_nxt = ge ? rs - {1'b0, den} : rs;
    q_nxt   = {q_r[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'(Q_W);
    end else begin
      done_r <= busy_r && (cnt_r == 5'd1);
      if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= {1'b0, num};
      q_r     <= '0;
      first_r <= 1'b1;
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      first_r <= 1'b0;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- sv/sthr_back.sv -----
// ----------------------------------------------------------------------------
// Back end
// Sequencer with the particle, vertex and height stores, one shared
// multiplier and the fraction divider; executes one queued item at a time.
// ----------------------------------------------------------------------------
module sthr_back import sthr_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
  parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int PAW = $clog2(MAX_PARTICLES);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int CAW = $clog2(CELL_COUNT);
  localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);
  localparam logic signed [49:0] ACC_HI = 50'sd140737488355327;
  localparam logic signed [49:0] ACC_LO = -50'sd140737488355328;

  part_t part_mem [MAX_PARTICLES];
  vtx_t  vtx_mem  [MAX_VERTICES];
  logic signed [31:0] h_mem [CELL_COUNT];

  state_t state_r, state_nxt;
  q_item_t it_r;

  part_t part_rd_r;
  vtx_t  vtx_rd_r;
  logic signed [31:0] h_rd_r;

  logic signed [ACC_W-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic signed [PROD_W-1:0] prod_r, p1_r;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  logic signed [GX_W-1:0] gx_r;
  vtx_t va_r, vb_r, vc_r;
  logic signed [DIF_W-1:0] bx_r, bz_r, cx_r, cz_r, dx_r, dz_r;
  logic signed [32:0] dby_r, dcy_r;
  logic signed [DET_W-1:0] det_r, nu_r, nv_r;
  logic [DIV_W-1:0] dabs_r;
  logic neg_r;
  logic signed [BB_W-1:0] x0_r, x1_r, z0_r, z1_r, x_r, z_r;
  logic [CAW-1:0] cell_r;
  logic [Q_W-1:0] u_r, v_r;
  logic signed [31:0] y_r;
  logic signed [31:0] rd_val_r;
  logic degen_r;

  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic out_load;

  logic part_we, vtx_we, h_we;
  logic [CAW-1:0] h_waddr, h_raddr;
  logic signed [31:0] h_wdata;
  logic [VAW-1:0] vtx_raddr;
  vtx_t vtx_wdata;

  logic div_start, div_done;
  logic [DIV_W-1:0] div_num;
  logic [Q_W-1:0] div_quot;

  logic [31:0] q_idx32, q_ra32, it_idx32, it_ra32, it_rb32, it_rc32;
  logic q_pidx_ok, q_cidx_ok, it_ra_pok, it_vidx_ok, it_cidx_ok;
  logic va_ok, vb_ok, vc_ok;
  logic [COLS_W-1:0] cols;
  logic [ROWS_W-1:0] rows;
  logic [16:0] w_sat;
  part_t p_use;
  logic signed [GX_W-1:0] prj_clamped;
  logic signed [GX_W-1:0] mnx, mxx, mnz, mxz;
  logic signed [BB_W-1:0] bx0, bx1, bz0, bz1, cols_m1, rows_m1;
  logic signed [DET_W:0] nuv_sum;
  logic pt_in;
  logic signed [50:0] hsum;
  logic signed [35:0] y36;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc,
                                                       input logic signed [PROD_W-1:0] p);
    logic signed [49:0] s;
    s = 50'(acc) + 50'(p);
    if (s > ACC_HI) begin
      return ACC_W'(ACC_HI);
    end else if (s < ACC_LO) begin
      return ACC_W'(ACC_LO);
    end
    return ACC_W'(s);
  endfunction

  function automatic logic signed [GX_W-1:0] clamp_grid(input logic signed [PROD_W-1:0] p);
    logic signed [47:0] v;
    v = 48'(p >>> 16);
    if (v > 48'(GRID_LIMIT)) begin
      return GRID_LIMIT;
    end else if (v < -48'(GRID_LIMIT)) begin
      return -GRID_LIMIT;
    end
    return GX_W'(v);
  endfunction

  function automatic logic signed [GX_W-1:0] min3(input logic signed [GX_W-1:0] a,
                                                  input logic signed [GX_W-1:0] b,
                                                  input logic signed [GX_W-1:0] c);
    logic signed [GX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [GX_W-1:0] max3(input logic signed [GX_W-1:0] a,
                                                  input logic signed [GX_W-1:0] b,
                                                  input logic signed [GX_W-1:0] c);
    logic signed [GX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Range checks and decoded configuration.
  always_comb begin
    q_idx32    = 32'(q_item.item.index);
    q_ra32     = 32'(q_item.item.ref_a);
    it_idx32   = 32'(it_r.item.index);
    it_ra32    = 32'(it_r.item.ref_a);
    it_rb32    = 32'(it_r.item.ref_b);
    it_rc32    = 32'(it_r.item.ref_c);
    q_pidx_ok  = q_idx32 < 32'(MAX_PARTICLES);
    q_cidx_ok  = q_idx32 < 32'(CELL_COUNT);
    it_ra_pok  = it_ra32 < 32'(MAX_PARTICLES);
    it_vidx_ok = it_idx32 < 32'(MAX_VERTICES);
    it_cidx_ok = it_idx32 < 32'(CELL_COUNT);
    va_ok      = it_ra32 < 32'(MAX_VERTICES);
    vb_ok      = it_rb32 < 32'(MAX_VERTICES);
    vc_ok      = it_rc32 < 32'(MAX_VERTICES);
    if (cfg.grid_columns == 7'd0) begin
      cols = COLS_W'(1);
    end else if (32'(cfg.grid_columns) > 32'(MAX_COLUMNS)) begin
      cols = COLS_W'(MAX_COLUMNS);
    end else begin
      cols = COLS_W'(cfg.grid_columns);
    end
    if (cfg.grid_rows == 7'd0) begin
      rows = ROWS_W'(1);
    end else if (32'(cfg.grid_rows) > 32'(MAX_ROWS)) begin
      rows = ROWS_W'(MAX_ROWS);
    end else begin
      rows = ROWS_W'(cfg.grid_rows);
    end
    cols_m1 = BB_W'(cols) - BB_W'(1);
    rows_m1 = BB_W'(rows) - BB_W'(1);
    w_sat   = (it_r.item.weight > WEIGHT_ONE) ? WEIGHT_ONE : it_r.item.weight;
    p_use   = it_ra_pok ? part_rd_r : '0;
    prj_clamped = clamp_grid(prod_r);
    mnx = min3(va_r.gx, vb_r.gx, vc_r.gx);
    mxx = max3(va_r.gx, vb_r.gx, vc_r.gx);
    mnz = min3(va_r.gz, vb_r.gz, vc_r.gz);
    mxz = max3(va_r.gz, vb_r.gz, vc_r.gz);
    bx0 = BB_W'((30'(mnx) + 30'sd65535) >>> 16);
    bx1 = BB_W'(mxx >>> 16);
    bz0 = BB_W'((30'(mnz) + 30'sd65535) >>> 16);
    bz1 = BB_W'(mxz >>> 16);
    if (bx0 < 0) bx0 = '0;
    if (bz0 < 0) bz0 = '0;
    if (bx1 > cols_m1) bx1 = cols_m1;
    if (bz1 > rows_m1) bz1 = rows_m1;
    nuv_sum = (DET_W+1)'(nu_r) + (DET_W+1)'(nv_r);
    pt_in   = !nu_r[DET_W-1] && !nv_r[DET_W-1] && (nuv_sum <= $signed({2'b00, dabs_r}));
    hsum    = 51'(p1_r) + 51'(prod_r);
    y36     = 36'(va_r.hy) + 36'(hsum >>> 16) + HEIGHT_BIAS;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    part_we   = 1'b0;
    vtx_we    = 1'b0;
    h_we      = 1'b0;
    h_waddr   = cell_r;
    h_wdata   = y_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = DIV_W'(nu_r);
    out_load  = 1'b0;
    vtx_raddr = q_ra32[VAW-1:0];
    vtx_wdata.gx = gx_r;
    vtx_wdata.hy = 32'(acc_y_r >>> 16);
    vtx_wdata.gz = prj_clamped;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_LOAD: begin
              part_we   = q_pidx_ok;
              state_nxt = ST_DONE;
            end
            OP_INFL: state_nxt = ST_INF_MX;
            OP_TRI:  state_nxt = ST_TRI_B;
            OP_WRH: begin
              h_we      = q_cidx_ok;
              h_waddr   = q_idx32[CAW-1:0];
              h_wdata   = q_item.item.val_y;
              state_nxt = ST_DONE;
            end
            OP_RDH:  state_nxt = ST_RD;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INF_MX: begin
        mul_a = MA_W'(p_use.px);
        mul_b = MB_W'(w_sat);
        state_nxt = ST_INF_MY;
      end
      ST_INF_MY: begin
        mul_a = MA_W'(p_use.py);
        mul_b = MB_W'(w_sat);
        state_nxt = ST_INF_MZ;
      end
      ST_INF_MZ: begin
        mul_a = MA_W'(p_use.pz);
        mul_b = MB_W'(w_sat);
        state_nxt = ST_INF_AZ;
      end
      ST_INF_AZ: begin
        state_nxt = (it_r.item.slot == 2'd3 && it_vidx_ok) ? ST_PRJ_X : ST_DONE;
      end
      ST_PRJ_X: begin
        mul_a = MA_W'(acc_x_r >>> 16) - MA_W'(cfg.bed_origin_x) + OFFSET_X;
        mul_b = MB_W'(cfg.inv_cell_x);
        state_nxt = ST_PRJ_Z;
      end
      ST_PRJ_Z: begin
        mul_a = MA_W'(acc_z_r >>> 16) - MA_W'(cfg.bed_origin_z) + OFFSET_Z;
        mul_b = MB_W'(cfg.inv_cell_z);
        state_nxt = ST_PRJ_W;
      end
      ST_PRJ_W: begin
        vtx_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_TRI_B: begin
        vtx_raddr = it_rb32[VAW-1:0];
        state_nxt = ST_TRI_C;
      end
      ST_TRI_C: begin
        vtx_raddr = it_rc32[VAW-1:0];
        state_nxt = ST_TRI_D;
      end
      ST_TRI_D:   state_nxt = ST_TRI_DIF;
      ST_TRI_DIF: state_nxt = ST_DET1;
      ST_DET1: begin
        mul_a = MA_W'(bx_r);
        mul_b = cz_r;
        state_nxt = ST_DET2;
      end
      ST_DET2: begin
        mul_a = MA_W'(bz_r);
        mul_b = cx_r;
        state_nxt = ST_DET3;
      end
      ST_DET3: state_nxt = ST_BOX;
      ST_BOX:  state_nxt = (det_r == '0) ? ST_DONE : ST_BOX_CHK;
      ST_BOX_CHK: begin
        state_nxt = (x0_r > x1_r || z0_r > z1_r) ? ST_DONE : ST_PT_SET;
      end
      ST_PT_SET: state_nxt = ST_NU1;
      ST_NU1: begin
        mul_a = MA_W'(cz_r);
        mul_b = dx_r;
        state_nxt = ST_NU2;
      end
      ST_NU2: begin
        mul_a = MA_W'(cx_r);
        mul_b = dz_r;
        state_nxt = ST_NV1;
      end
      ST_NV1: begin
        mul_a = MA_W'(bx_r);
        mul_b = dz_r;
        state_nxt = ST_NV2;
      end
      ST_NV2: begin
        mul_a = MA_W'(bz_r);
        mul_b = dx_r;
        state_nxt = ST_PT_NV;
      end
      ST_PT_NV: state_nxt = ST_PT_TST;
      ST_PT_TST: begin
        if (pt_in) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_U;
        end else begin
          state_nxt = ST_PT_NEXT;
        end
      end
      ST_DIV_U: begin
        div_num = DIV_W'(nv_r);
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_V;
        end
      end
      ST_DIV_V: begin
        if (div_done) begin
          state_nxt = ST_HGT1;
        end
      end
      ST_HGT1: begin
        mul_a = MA_W'(dby_r);
        mul_b = MB_W'(u_r);
        state_nxt = ST_HGT2;
      end
      ST_HGT2: begin
        mul_a = MA_W'(dcy_r);
        mul_b = MB_W'(v_r);
        state_nxt = ST_HGT3;
      end
      ST_HGT3: state_nxt = ST_HGT_WR;
      ST_HGT_WR: begin
        h_we      = (y_r > h_rd_r);
        state_nxt = ST_PT_NEXT;
      end
      ST_PT_NEXT: begin
        state_nxt = (x_r == x1_r && z_r == z1_r) ? ST_DONE : ST_PT_SET;
      end
      ST_RD:   state_nxt = ST_RD_W;
      ST_RD_W: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign h_raddr = (state_r == ST_RD) ? it_idx32[CAW-1:0] : cell_r;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end else begin
      case (state_r)
        ST_INF_MX: begin
          if (it_r.item.slot == 2'd0) begin
            acc_x_r <= '0;
            acc_y_r <= '0;
            acc_z_r <= '0;
          end
        end
        ST_INF_MY: acc_x_r <= sat_acc(acc_x_r, prod_r);
        ST_INF_MZ: acc_y_r <= sat_acc(acc_y_r, prod_r);
        ST_INF_AZ: acc_z_r <= sat_acc(acc_z_r, prod_r);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (out_load) begin
      out_item_r.read_value <= rd_val_r;
      out_item_r.degenerate <= degen_r;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          it_r     <= q_item;
          rd_val_r <= '0;
          degen_r  <= 1'b0;
        end
      end
      ST_PRJ_Z: gx_r <= prj_clamped;
      ST_TRI_B: va_r <= va_ok ? vtx_rd_r : '0;
      ST_TRI_C: vb_r <= vb_ok ? vtx_rd_r : '0;
      ST_TRI_D: vc_r <= vc_ok ? vtx_rd_r : '0;
      ST_TRI_DIF: begin
        bx_r  <= DIF_W'(vb_r.gx) - DIF_W'(va_r.gx);
        bz_r  <= DIF_W'(vb_r.gz) - DIF_W'(va_r.gz);
        cx_r  <= DIF_W'(vc_r.gx) - DIF_W'(va_r.gx);
        cz_r  <= DIF_W'(vc_r.gz) - DIF_W'(va_r.gz);
        dby_r <= 33'(vb_r.hy) - 33'(va_r.hy);
        dcy_r <= 33'(vc_r.hy) - 33'(va_r.hy);
      end
      ST_DET2: p1_r <= prod_r;
      ST_DET3: det_r <= DET_W'(p1_r - prod_r);
      ST_BOX: begin
        degen_r <= (det_r == '0);
        neg_r   <= det_r[DET_W-1];
        dabs_r  <= DIV_W'(det_r[DET_W-1] ? -det_r : det_r);
        x0_r    <= bx0;
        x1_r    <= bx1;
        z0_r    <= bz0;
        z1_r    <= bz1;
      end
      ST_BOX_CHK: begin
        x_r <= x0_r;
        z_r <= z0_r;
      end
      ST_PT_SET: begin
        dx_r   <= DIF_W'({x_r, 16'b0}) - DIF_W'(va_r.gx);
        dz_r   <= DIF_W'({z_r, 16'b0}) - DIF_W'(va_r.gz);
        cell_r <= CAW'(CAW'(z_r[BB_W-2:0]) * CAW'(cols) + CAW'(x_r[BB_W-2:0]));
      end
      ST_NV1: nu_r <= DET_W'(neg_r ? prod_r - p1_r : p1_r - prod_r);
      ST_NV2: p1_r <= prod_r;
      ST_NU2: p1_r <= prod_r;
      ST_PT_NV: nv_r <= DET_W'(neg_r ? prod_r - p1_r : p1_r - prod_r);
      ST_DIV_U: begin
        if (div_done) u_r <= div_quot;
      end
      ST_DIV_V: begin
        if (div_done) v_r <= div_quot;
      end
      ST_HGT2: p1_r <= prod_r;
      ST_HGT3: begin
        if (y36 > 36'sd2147483647) begin
          y_r <= 32'sh7fffffff;
        end else if (y36 < -36'sd2147483648) begin
          y_r <= 32'sh80000000;
        end else begin
          y_r <= 32'(y36);
        end
      end
      ST_PT_NEXT: begin
        if (x_r == x1_r) begin
          x_r <= x0_r;
          z_r <= z_r + BB_W'(1);
        end else begin
          x_r <= x_r + BB_W'(1);
        end
      end
      ST_RD_W: rd_val_r <= it_cidx_ok ? h_rd_r : '0;
      default: ;
    endcase
  end

  // Stores.
  always_ff @(posedge clk) begin
    if (part_we) begin
      part_mem[q_idx32[PAW-1:0]] <= '{px: q_item.item.val_x, py: q_item.item.val_y,
                                      pz: q_item.item.val_z};
    end
    if (state_r == ST_IDLE) begin
      part_rd_r <= part_mem[q_ra32[PAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (vtx_we) begin
      vtx_mem[it_idx32[VAW-1:0]] <= vtx_wdata;
    end
    vtx_rd_r <= vtx_mem[vtx_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
    h_rd_r <= h_mem[h_raddr];
  end

  sthr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dabs_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_degen_tri: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && degen_r) |-> (it_r.op == OP_TRI))
    else $error("degenerate flag set for an item that is not a triangle");

  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && rd_val_r != '0) |-> (it_r.op == OP_RDH))
    else $error("read value set for an item that is not a height read");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_U || state_r == ST_DIV_V))
    else $error("divider finished outside a divide step");

  a_hwr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HGT_WR) |-> ($past(state_r) == ST_HGT3))
    else $error("height update reached without interpolation");

endmodule

// ----- sv/skinned_triangle_height_raster_top.sv -----
// ----------------------------------------------------------------------------
// Skinned triangle height raster, top level
// Holds the configuration registers and joins the front queue to the back end.
// ----------------------------------------------------------------------------
// An influence item on slot 3 also projects and writes its vertex; a triangle
// visits every cell of its box, and each cell inside the triangle runs two
// divides on the one-bit-a-cycle divider; all steps share the one multiplier.
// One item is processed at a time; the queue takes two more. Reset is
// synchronous and active low; the stores are not cleared.
module skinned_triangle_height_raster_top import sthr_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF,
  parameter int MAX_VERTICES  = MAX_VERTICES_DEF,
  parameter int MAX_COLUMNS   = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg_r;
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_columns <= 7'd64;
      cfg_r.grid_rows    <= 7'd64;
      cfg_r.inv_cell_x   <= 24'd65536;
      cfg_r.inv_cell_z   <= 24'd65536;
      cfg_r.bed_origin_x <= '0;
      cfg_r.bed_origin_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_COLUMNS: cfg_r.grid_columns <= cfg_data[6:0];
        CFG_GRID_ROWS:    cfg_r.grid_rows    <= cfg_data[6:0];
        CFG_INV_CELL_X:   cfg_r.inv_cell_x   <= cfg_data[23:0];
        CFG_INV_CELL_Z:   cfg_r.inv_cell_z   <= cfg_data[23:0];
        CFG_BED_ORIGIN_X: cfg_r.bed_origin_x <= cfg_data;
        CFG_BED_ORIGIN_Z: cfg_r.bed_origin_z <= cfg_data;
        default: ;
      endcase
    end
  end

  sthr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sthr_back #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_VERTICES  (MAX_VERTICES),
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROWS      (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- tb/skinned_triangle_height_raster_top_tb.sv -----
// ----------------------------------------------------------------------------
// Skinned triangle height raster testbench
// Drives particle loads, vertex influence sequences, triangles and height
// cell writes and reads through the valid/stall item channel. Each accepted
// item is run through a fixed-point model of the block, and every result
// item is compared field by field with the oldest expected result. The run
// steps through several grid and projection settings, idles both channels
// at random and holds the result channel off for a long stretch in two runs.
// ----------------------------------------------------------------------------
module skinned_triangle_height_raster_top_tb;
  import sthr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int PART_DEPTH = 1024;
  localparam int VERT_DEPTH = 1024;
  localparam int CELL_DEPTH = 4096;
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST = 3'd7;
  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -64'sd140737488355328;
  localparam longint GRID_HI = 64'sd134217728;
  localparam longint BIAS_LSB = 64'sd43;
  localparam longint OFS_X_LSB = 64'sd4129;
  localparam longint OFS_Z_LSB = 64'sd1704;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  skinned_triangle_height_raster_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model state.
  longint grid_cols_q, grid_rows_q, inv_x_q, inv_z_q, origin_x_q, origin_z_q;
  int part_x[PART_DEPTH], part_y[PART_DEPTH], part_z[PART_DEPTH];
  int vtx_gx[VERT_DEPTH], vtx_hy[VERT_DEPTH], vtx_gz[VERT_DEPTH];
  longint sum_x, sum_y, sum_z;
  int height_model[CELL_DEPTH];
  bit cell_written[CELL_DEPTH];
  int written_cells[$];
  int good_parts[$];
  int good_verts[$];

  out_item_t pending_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  bit hold_req = 0;
  bit tx_active = 0;
  int burst_left = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  function automatic longint frac_q16(longint n, longint d);
    longint q, r;
    q = 0;
    r = n;
    if (r >= d) begin
      q = 1;
      r = r - d;
    end
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic int project_axis(longint acc, longint origin, longint ofs, longint inv);
    longint d;
    d = (acc >>> 16) - origin + ofs;
    return int'(clamp((d * inv) >>> 16, -GRID_HI, GRID_HI));
  endfunction

  function automatic longint cols_eff();
    return grid_cols_q == 0 ? 1 : (grid_cols_q > MAX_COLUMNS_DEF ? MAX_COLUMNS_DEF : grid_cols_q);
  endfunction

  function automatic longint rows_eff();
    return grid_rows_q == 0 ? 1 : (grid_rows_q > MAX_ROWS_DEF ? MAX_ROWS_DEF : grid_rows_q);
  endfunction

  // Cells inside the triangle and their raised heights; returns the degenerate flag.
  function automatic bit raster_cells(int ia, int ib, int ic, output int cells[$],
                                      output int heights[$]);
    longint ax, ay, az, pbx, by, pbz, pcx, cy, pcz, bx, bz, cx, cz, det;
    longint cols, rows, x0, x1, z0, z1, dx, dz, nu, nv, d, u, v, y;
    cells = {};
    heights = {};
    cols = cols_eff();
    rows = rows_eff();
    ax = vtx_gx[ia]; ay = vtx_hy[ia]; az = vtx_gz[ia];
    pbx = vtx_gx[ib]; by = vtx_hy[ib]; pbz = vtx_gz[ib];
    pcx = vtx_gx[ic]; cy = vtx_hy[ic]; pcz = vtx_gz[ic];
    bx = pbx - ax; bz = pbz - az; cx = pcx - ax; cz = pcz - az;
    det = bx * cz - bz * cx;
    if (det == 0) return 1;
    x0 = -((-min3(ax, pbx, pcx)) >>> 16);
    if (x0 < 0) x0 = 0;
    x1 = max3(ax, pbx, pcx) >>> 16;
    if (x1 > cols - 1) x1 = cols - 1;
    z0 = -((-min3(az, pbz, pcz)) >>> 16);
    if (z0 < 0) z0 = 0;
    z1 = max3(az, pbz, pcz) >>> 16;
    if (z1 > rows - 1) z1 = rows - 1;
    for (longint z = z0; z <= z1; z++) begin
      for (longint x = x0; x <= x1; x++) begin
        dx = x * 65536 - ax;
        dz = z * 65536 - az;
        nu = dx * cz - dz * cx;
        nv = bx * dz - bz * dx;
        d = det;
        if (d < 0) begin
          d = -d; nu = -nu; nv = -nv;
        end
        if (nu >= 0 && nv >= 0 && nu + nv <= d) begin
          u = frac_q16(nu, d);
          v = frac_q16(nv, d);
          y = ay + ((u * (by - ay) + v * (cy - ay)) >>> 16) + BIAS_LSB;
          cells.push_back(int'(z * cols + x));
          heights.push_back(int'(clamp(y, -64'sd2147483648, 64'sd2147483647)));
        end
      end
    end
    return 0;
  endfunction

  function automatic out_item_t predict_height_item(in_item_t it);
    out_item_t r;
    longint w;
    int px, py, pz;
    int cells[$];
    int heights[$];
    r = '0;
    w = it.weight > WEIGHT_ONE ? 65536 : it.weight;
    case (it.mode)
      MODE_LOAD: begin
        if (it.index < PART_DEPTH) begin
          part_x[it.index] = it.val_x;
          part_y[it.index] = it.val_y;
          part_z[it.index] = it.val_z;
        end
      end
      MODE_INFL: begin
        px = part_x[it.ref_a]; py = part_y[it.ref_a]; pz = part_z[it.ref_a];
        if (it.slot == 0) begin
          sum_x = 0; sum_y = 0; sum_z = 0;
        end
        sum_x = clamp(sum_x + longint'(px) * w, ACC_LO, ACC_HI);
        sum_y = clamp(sum_y + longint'(py) * w, ACC_LO, ACC_HI);
        sum_z = clamp(sum_z + longint'(pz) * w, ACC_LO, ACC_HI);
        if (it.slot == 3 && it.index < VERT_DEPTH) begin
          vtx_gx[it.index] = project_axis(sum_x, origin_x_q, OFS_X_LSB, inv_x_q);
          vtx_hy[it.index] = int'(sum_y >>> 16);
          vtx_gz[it.index] = project_axis(sum_z, origin_z_q, OFS_Z_LSB, inv_z_q);
        end
      end
      MODE_TRI: begin
        r.degenerate = raster_cells(it.ref_a, it.ref_b, it.ref_c, cells, heights);
        foreach (cells[i]) begin
          if (heights[i] > height_model[cells[i]]) height_model[cells[i]] = heights[i];
        end
      end
      MODE_WRITE: begin
        height_model[it.index] = it.val_y;
        if (!cell_written[it.index]) begin
          cell_written[it.index] = 1;
          written_cells.push_back(it.index);
        end
      end
      MODE_READ: r.read_value = height_model[it.index];
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expected result: read_value %0d degenerate %0d",
               out_item.read_value, out_item.degenerate);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_value !== want.read_value) begin
          $error("read_value expected %0d actual %0d", want.read_value, out_item.read_value);
          fail_count++;
        end
        if (out_item.degenerate !== want.degenerate) begin
          $error("degenerate expected %0d actual %0d", want.degenerate, out_item.degenerate);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int mode_cycles;
    int rx_pattern;
    mode_cycles = 0;
    rx_pattern = 0;
    out_stall <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode_cycles++;
      if (mode_cycles > 250) begin
        mode_cycles = 0;
        rx_pattern = $urandom_range(0, 2);
      end
      case (rx_pattern)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 99) < 35);
        default: out_stall <= (mode_cycles % 4 == 1);
      endcase
    end
  end

  task automatic send_item(in_item_t it);
    in_valid <= 1;
    in_item <= it;
    tx_active = 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_height_item(it));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 0;
      tx_active = 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  function automatic in_item_t rand_item(logic [2:0] mode);
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it.mode = mode;
    return it;
  endfunction

  task automatic wait_idle();
    if (tx_active) begin
      in_valid <= 0;
      tx_active = 0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_GRID_COLUMNS: grid_cols_q = value[6:0];
      CFG_GRID_ROWS: grid_rows_q = value[6:0];
      CFG_INV_CELL_X: inv_x_q = value[23:0];
      CFG_INV_CELL_Z: inv_z_q = value[23:0];
      CFG_BED_ORIGIN_X: origin_x_q = longint'(signed'(value));
      default: origin_z_q = longint'(signed'(value));
    endcase
  endtask

  task automatic apply_grid_setup(int cols, int rows, int invx, int invz, int ox, int oz);
    wait_idle();
    write_reg(CFG_GRID_COLUMNS, cols);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_INV_CELL_X, invx);
    write_reg(CFG_INV_CELL_Z, invz);
    write_reg(CFG_BED_ORIGIN_X, ox);
    write_reg(CFG_BED_ORIGIN_Z, oz);
    cfg_we <= 0;
    good_parts = {};
    good_verts = {};
  endtask

  task automatic send_influence(int vidx, int slot, int part, logic [16:0] w);
    in_item_t it;
    it = rand_item(MODE_INFL);
    it.index = vidx;
    it.slot = slot;
    it.ref_a = part;
    it.weight = w;
    send_item(it);
  endtask

  // Triangles only raise cells that already hold a written height.
  task automatic send_triangle(int ia, int ib, int ic);
    in_item_t it;
    int cells[$];
    int heights[$];
    bit flat;
    flat = raster_cells(ia, ib, ic, cells, heights);
    foreach (cells[i]) begin
      if (!cell_written[cells[i]]) begin
        it = rand_item(MODE_WRITE);
        it.index = cells[i];
        send_item(it);
      end
    end
    it = rand_item(MODE_TRI);
    it.ref_a = ia;
    it.ref_b = ib;
    it.ref_c = ic;
    send_item(it);
  endtask

  task automatic load_near_origin();
    in_item_t it;
    longint span_x, span_z;
    span_x = (64'sd5 <<< 32) / inv_x_q;
    span_z = (64'sd5 <<< 32) / inv_z_q;
    if (span_x > 64'sd1073741824) span_x = 64'sd1073741824;
    if (span_z > 64'sd1073741824) span_z = 64'sd1073741824;
    it = rand_item(MODE_LOAD);
    it.index = $urandom_range(0, PART_DEPTH - 1);
    it.val_x = int'(clamp(origin_x_q + $urandom_range(0, int'(span_x)),
                          -64'sd2147483648, 64'sd2147483647));
    it.val_z = int'(clamp(origin_z_q + $urandom_range(0, int'(span_z)),
                          -64'sd2147483648, 64'sd2147483647));
    if ($urandom_range(0, 1)) it.val_y = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
    send_item(it);
    good_parts.push_back(it.index);
  endtask

  task automatic build_vertex(int vidx);
    int c[3];
    int t;
    c[0] = $urandom_range(0, 65536);
    c[1] = $urandom_range(0, 65536);
    c[2] = $urandom_range(0, 65536);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2 - i; j++) begin
        if (c[j] > c[j + 1]) begin
          t = c[j]; c[j] = c[j + 1]; c[j + 1] = t;
        end
      end
    end
    send_influence(vidx, 0, good_parts[$urandom_range(0, good_parts.size() - 1)], c[0]);
    send_influence(vidx, 1, good_parts[$urandom_range(0, good_parts.size() - 1)], c[1] - c[0]);
    send_influence(vidx, 2, good_parts[$urandom_range(0, good_parts.size() - 1)], c[2] - c[1]);
    send_influence(vidx, 3, good_parts[$urandom_range(0, good_parts.size() - 1)], 65536 - c[2]);
    foreach (good_verts[i]) if (good_verts[i] == vidx) good_verts.delete(i);
    good_verts.push_back(vidx);
  endtask

  task automatic test_directed_extremes();
    in_item_t it;
    apply_grid_setup(4, 4, 65536, 65536, 0, 0);
    it = rand_item(MODE_LOAD);
    it.index = 0; it.val_x = 32'sh8000_0000; it.val_y = 0; it.val_z = 32'sh8000_0000;
    send_item(it);
    it = rand_item(MODE_LOAD);
    it.index = 1023; it.val_x = 32'sh7fff_ffff; it.val_y = 32'sh7fff_ffff;
    it.val_z = 32'sh8000_0000;
    send_item(it);
    it = rand_item(MODE_LOAD);
    it.index = 512; it.val_x = 32'sh8000_0000; it.val_y = 32'sh8000_0000;
    it.val_z = 32'sh7fff_ffff;
    send_item(it);
    it = rand_item(MODE_LOAD);
    it.index = 4095;
    send_item(it);
    // Weights above one saturate, and four full-scale terms overflow the sums.
    for (int s = 0; s < 4; s++) send_influence(0, s, 0, 17'h1ffff);
    for (int s = 0; s < 4; s++) send_influence(1023, s, 1023, WEIGHT_ONE);
    for (int s = 0; s < 4; s++) send_influence(341, s, 512, WEIGHT_ONE);
    send_influence(4095, 3, 512, 0);
    send_triangle(0, 1023, 341);
    send_triangle(341, 341, 341);
    it = rand_item(MODE_WRITE);
    it.index = 4095; it.val_y = 32'sh7fff_ffff;
    send_item(it);
    it = rand_item(MODE_READ);
    it.index = 4095;
    send_item(it);
    it = rand_item(MODE_WRITE);
    it.index = 2730; it.val_y = 32'sh8000_0000;
    send_item(it);
    it = rand_item(MODE_READ);
    it.index = 2730;
    send_item(it);
    it = rand_item(MODE_READ);
    it.index = 0;
    send_item(it);
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) send_item(rand_item(m));
  endtask

  task automatic test_random_mix(int cols, int rows, int invx, int invz, int ox, int oz,
                                 int count, bit hold_off);
    in_item_t it;
    int pick;
    int sent;
    int ia, ib, ic;
    apply_grid_setup(cols, rows, invx, invz, ox, oz);
    repeat (8) load_near_origin();
    if (hold_off) hold_req = 1;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || good_verts.size() < 3) begin
        build_vertex($urandom_range(0, VERT_DEPTH - 1));
        sent += 4;
      end else if (pick < 62) begin
        ia = good_verts[$urandom_range(0, good_verts.size() - 1)];
        ib = good_verts[$urandom_range(0, good_verts.size() - 1)];
        ic = ($urandom_range(0, 9) == 0) ? ia : good_verts[$urandom_range(0, good_verts.size() - 1)];
        send_triangle(ia, ib, ic);
        sent++;
      end else if (pick < 68) begin
        load_near_origin();
        sent++;
      end else if (pick < 77) begin
        it = rand_item(MODE_WRITE);
        send_item(it);
        sent++;
      end else if (pick < 88) begin
        if (written_cells.size() != 0) begin
          it = rand_item(MODE_READ);
          it.index = written_cells[$urandom_range(0, written_cells.size() - 1)];
          send_item(it);
          sent++;
        end
      end else if (pick < 92) begin
        send_item(rand_item($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)));
      end else if (pick < 95) begin
        it = rand_item(MODE_LOAD);
        it.index[11:10] = $urandom_range(1, 3);
        send_item(it);
      end else begin
        // Broken influence sequence with a random slot and raw weight.
        it = rand_item(MODE_INFL);
        it.ref_a = good_parts[$urandom_range(0, good_parts.size() - 1)];
        if ($urandom_range(0, 1)) it.index[11:10] = $urandom_range(1, 3);
        if (it.slot == 3 && it.index < VERT_DEPTH) begin
          foreach (good_verts[i]) if (good_verts[i] == it.index) good_verts.delete(i);
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    in_valid <= 0;
    in_item <= '0;
    cfg_we <= 0;
    cfg_index <= CFG_GRID_COLUMNS;
    cfg_data <= '0;
    rst_n <= 0;
    grid_cols_q = 64; grid_rows_q = 64;
    inv_x_q = 65536; inv_z_q = 65536;
    origin_x_q = 0; origin_z_q = 0;
    sum_x = 0; sum_y = 0; sum_z = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed_extremes();
    test_random_mix(64, 64, 65536, 65536, 0, 0, 260, 1);
    test_random_mix(8, 6, 131072, 98304, 32'sh0003_2000, -32'sh0001_8000, 260, 0);
    test_random_mix(1, 1, 65536, 65536, 0, 0, 200, 0);
    test_random_mix(0, 127, 16777215, 16777215, 32'sh8000_0000, 32'sh8000_0000, 240, 0);
    test_random_mix(127, 3, 1, 65536, 32'sh7fff_0000, 0, 200, 1);
    test_random_mix(5, 9, 40000, 200000, -32'sh0050_0000, 32'sh0123_4567, 260, 0);
    test_random_mix(16, 16, 65536, 65536, 32'sh0000_8000, 32'sh0000_8000, 300, 0);
    wait_idle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/sthr_pkg.sv
sv/sthr_front.sv
sv/sthr_div.sv
sv/sthr_back.sv
sv/skinned_triangle_height_raster_top.sv
tb/skinned_triangle_height_raster_top_tb.sv
